[hw/rtl/mwpt_pkg.sv]
// Package for the minimum weight path table: widths, entry layout, operation
// and status codes, and the sequencer state type.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mwpt_pkg;

   // Table size and the widths that follow from it.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);

   // Field widths of one word on either channel.
   localparam int MODE_W   = 2;
   localparam int ID_W     = 16;
   localparam int WEIGHT_W = 32;
   localparam int NODE_W   = 16;
   localparam int STATUS_W = 2;

   // Operation codes carried in the mode field.
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 2'd0,
      MODE_REMOVE  = 2'd1,
      MODE_FINDMIN = 2'd2,
      MODE_QUERY   = 2'd3
   } mode_type;

   // Status codes returned with every result.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   // One stored entry: id in the top bits, then weight, then last node.
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
      logic [NODE_W-1:0]   node;
   } entry_type;

   // Write and read requests from the sequencer to the entry store.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_INSERT = 5'b00010,
      S_SCAN   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/mwpt_if.sv]
// Channel interfaces of the minimum weight path table: the request channel
// and the response channel, each with valid, ready and the word's fields.
// Depends on mwpt_pkg for the field widths.
`default_nettype none

interface mwpt_req_if
   import mwpt_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ID_W-1:0]     path_id;
   logic [WEIGHT_W-1:0] weight;
   logic [NODE_W-1:0]   node_id;

   modport source (output valid, output mode, output path_id, output weight,
                   output node_id, input ready);
   modport sink   (input valid, input mode, input path_id, input weight,
                   input node_id, output ready);
endinterface

interface mwpt_rsp_if
   import mwpt_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [ID_W-1:0]     best_id;
   logic [WEIGHT_W-1:0] best_weight;
   logic [CNT_W-1:0]    entries_used;

   modport source (output valid, output status, output found, output best_id,
                   output best_weight, output entries_used, input ready);
   modport sink   (input valid, input status, input found, input best_id,
                   input best_weight, input entries_used, output ready);
endinterface

`default_nettype wire

[hw/rtl/mwpt_entry_ram.sv]
// Entry store of the minimum weight path table: one write port and one read
// port with registered read data. Contents are undefined until written.
// Depends on mwpt_pkg for the entry layout and the request structs.
`default_nettype none

module mwpt_entry_ram
   import mwpt_pkg::*;
(
   input  wire logic       clock,
   input  wire ram_wr_type wr_req,
   input  wire ram_rd_type rd_req,
   output      entry_type  rd_data_ff
);

   entry_type mem_ff [CAPACITY];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem_ff[wr_req.addr] <= wr_req.data;
      end
   end

   // Read port; the read data is registered, so it appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem_ff[rd_req.addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/min_weight_path_table_core.sv]
// The minimum weight path table keeps up to 64 paths (id, 16.16 weight, last
// node) packed without gaps in a single-port-write, single-port-read memory.
// One request word is taken at a time; the request channel is not ready until
// the operation has finished. An insert writes its entry in S_INSERT and then
// loads its response from S_DONE. Remove, find-min and query walk the table one
// entry per cycle through the memory read port, whose read data is registered.
// A query that hits in slot j stops there. A remove also stops walking at its
// hit and then moves the later entries down, again one per cycle. The request
// channel is ready again in the cycle after the response is loaded. The
// response sits in an output register, so a new request is accepted while the
// previous response waits to be taken. Only a response that is still held when
// the next one is ready stalls the block.
// No clearing pass is needed after reset.
// Depends on mwpt_pkg, mwpt_if and mwpt_entry_ram.
`default_nettype none

module min_weight_path_table_core
   import mwpt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mwpt_req_if.sink    req_if,
   mwpt_rsp_if.source  rsp_if
);

   state_type           state_ff, state_in;
   mode_type            mode_ff;
   logic [ID_W-1:0]     key_id_ff;
   logic [WEIGHT_W-1:0] key_weight_ff;
   logic [NODE_W-1:0]   key_node_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   status_type          status_ff, status_in;
   logic                found_ff, found_in;
   logic [ID_W-1:0]     best_id_ff, best_id_in;
   logic [WEIGHT_W-1:0] best_weight_ff, best_weight_in;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic                rsp_found_ff;
   logic [ID_W-1:0]     rsp_best_id_ff;
   logic [WEIGHT_W-1:0] rsp_best_weight_ff;
   logic [CNT_W-1:0]    rsp_entries_ff;

   ram_wr_type wr_req;
   ram_rd_type rd_req;
   entry_type  rd_data;
   logic       req_accept;
   logic       load_rsp;
   logic       leave;
   logic       weight_less;

   mwpt_entry_ram u_entry_ram (
      .clock      (clock),
      .wr_req     (wr_req),
      .rd_req     (rd_req),
      .rd_data_ff (rd_data)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // The single shared comparator of the find-min walk.
   assign weight_less = (rd_data.weight < best_weight_ff);

   // Sequencer: inserts, walks the table one entry per cycle, shifts after a remove hit.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      best_id_in     = best_id_ff;
      best_weight_in = best_weight_ff;
      wr_req         = '0;
      rd_req         = '0;
      load_rsp       = 1'b0;
      leave          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               issue_in       = '0;
               status_in      = STATUS_OK;
               found_in       = 1'b0;
               best_id_in     = '0;
               best_weight_in = '0;
               if (mode_type'(req_if.mode) == MODE_INSERT) begin
                  state_in = S_INSERT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_INSERT: begin
            if (count_ff >= CAPACITY_CNT) begin
               status_in = STATUS_FULL;
            end else begin
               wr_req.en          = 1'b1;
               wr_req.addr        = count_ff[IDX_W-1:0];
               wr_req.data.id     = key_id_ff;
               wr_req.data.weight = key_weight_ff;
               wr_req.data.node   = key_node_ff;
               count_in           = count_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end

         S_SCAN: begin
            // Examine the word read in the previous cycle.
            if (rd_valid_ff) begin
               case (mode_ff)
                  MODE_REMOVE: begin
                     if (rd_data.id == key_id_ff) begin
                        issue_in = CNT_W'(rd_idx_ff) + CNT_W'(1);
                        rd_idx_in = rd_idx_ff;
                        state_in = S_SHIFT;
                        leave    = 1'b1;
                     end
                  end
                  MODE_FINDMIN: begin
                     if ((rd_idx_ff == '0) || weight_less) begin
                        best_id_in     = rd_data.id;
                        best_weight_in = rd_data.weight;
                        found_in       = 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     if (rd_data.node == key_node_ff) begin
                        found_in = 1'b1;
                        state_in = S_DONE;
                        leave    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // Issue the next read, or close the walk once nothing is in flight.
            if (!leave) begin
               if (issue_ff != count_ff) begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = issue_ff[IDX_W-1:0];
                  rd_valid_in = 1'b1;
                  rd_idx_in   = issue_ff[IDX_W-1:0];
                  issue_in    = issue_ff + CNT_W'(1);
               end else if (!rd_valid_ff) begin
                  if (mode_ff == MODE_REMOVE) begin
                     status_in = STATUS_NOT_FOUND;
                  end else if ((mode_ff == MODE_FINDMIN) && (count_ff == '0)) begin
                     status_in = STATUS_EMPTY;
                  end
                  state_in = S_DONE;
               end
            end
         end

         S_SHIFT: begin
            // Each word read from one slot up is written back one slot down.
            if (rd_valid_ff) begin
               wr_req.en   = 1'b1;
               wr_req.addr = rd_idx_ff;
               wr_req.data = rd_data;
            end
            if (issue_ff != count_ff) begin
               rd_req.en   = 1'b1;
               rd_req.addr = issue_ff[IDX_W-1:0];
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff[IDX_W-1:0] - IDX_W'(1);
               issue_in    = issue_ff + CNT_W'(1);
            end else if (!rd_valid_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Working registers of the current operation.
   always_ff @(posedge clock) begin
      issue_ff       <= issue_in;
      rd_idx_ff      <= rd_idx_in;
      status_ff      <= status_in;
      found_ff       <= found_in;
      best_id_ff     <= best_id_in;
      best_weight_ff <= best_weight_in;
      if (req_accept) begin
         mode_ff       <= mode_type'(req_if.mode);
         key_id_ff     <= req_if.path_id;
         key_weight_ff <= req_if.weight;
         key_node_ff   <= req_if.node_id;
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff      <= status_ff;
         rsp_found_ff       <= found_ff;
         rsp_best_id_ff     <= best_id_ff;
         rsp_best_weight_ff <= best_weight_ff;
         rsp_entries_ff     <= count_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.best_id      = rsp_best_id_ff;
   assign rsp_if.best_weight  = rsp_best_weight_ff;
   assign rsp_if.entries_used = rsp_entries_ff;

endmodule

`default_nettype wire

[bench/path_table_monitor.sv]
// Monitor for the minimum weight path table: watches both channels, keeps its
// own copy of the path table, predicts each response word and compares it.
// Depends on mwpt_pkg and the channel interfaces in mwpt_if.
`timescale 1ns / 1ps

module path_table_monitor
   import mwpt_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   mwpt_req_if   req_mon,
   mwpt_rsp_if   rsp_mon,
   output int    failures,
   output int    awaited
);

   // One predicted response word.
   typedef struct {
      status_type          status;
      logic                found;
      logic [ID_W-1:0]     best_id;
      logic [WEIGHT_W-1:0] best_weight;
      logic [CNT_W-1:0]    entries_used;
   } table_reply_type;

   // Shadow of the table, slot 0 first, always compacted.
   entry_type       held_paths[$];
   table_reply_type reply_queue[$];

   // Applies one request word to the shadow table and returns the response.
   function automatic table_reply_type apply_request(mode_type op,
                                                     logic [ID_W-1:0] id,
                                                     logic [WEIGHT_W-1:0] weight,
                                                     logic [NODE_W-1:0] node);
      table_reply_type r;
      entry_type       fresh;
      int              slot;
      int              best;
      r.status      = STATUS_OK;
      r.found       = 1'b0;
      r.best_id     = '0;
      r.best_weight = '0;
      case (op)
         MODE_INSERT: begin
            if (held_paths.size() >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               fresh.id     = id;
               fresh.weight = weight;
               fresh.node   = node;
               held_paths.push_back(fresh);
            end
         end
         MODE_REMOVE: begin
            // Only the lowest matching slot goes; later entries close the gap.
            slot = -1;
            foreach (held_paths[i]) begin
               if (slot < 0 && held_paths[i].id == id) slot = i;
            end
            if (slot >= 0) held_paths.delete(slot);
            else r.status = STATUS_NOT_FOUND;
         end
         MODE_FINDMIN: begin
            // Strictly lower weight is needed to displace, so ties keep the earliest.
            if (held_paths.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best = 0;
               foreach (held_paths[i]) begin
                  if (held_paths[i].weight < held_paths[best].weight) best = i;
               end
               r.found       = 1'b1;
               r.best_id     = held_paths[best].id;
               r.best_weight = held_paths[best].weight;
            end
         end
         default: begin
            foreach (held_paths[i]) begin
               if (held_paths[i].node == node) r.found = 1'b1;
            end
         end
      endcase
      r.entries_used = CNT_W'(held_paths.size());
      return r;
   endfunction

   task automatic check_field(string name, logic [WEIGHT_W-1:0] want,
                              logic [WEIGHT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // Requests are predicted at the edge that accepts them; responses are
   // matched against the oldest prediction at the edge that takes them.
   always @(posedge clock) begin
      table_reply_type want;
      if (reset) begin
         held_paths.delete();
         reply_queue.delete();
         failures = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            reply_queue.push_back(apply_request(mode_type'(req_mon.mode), req_mon.path_id,
                                                req_mon.weight, req_mon.node_id));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reply_queue.size() == 0) begin
               $error("Response word arrived with no request outstanding");
               failures++;
            end else begin
               want = reply_queue.pop_front();
               check_field("status", want.status, rsp_mon.status);
               check_field("found", want.found, rsp_mon.found);
               check_field("best_id", want.best_id, rsp_mon.best_id);
               check_field("best_weight", want.best_weight, rsp_mon.best_weight);
               check_field("entries_used", want.entries_used, rsp_mon.entries_used);
            end
         end
      end
      awaited = reply_queue.size();
   end

endmodule

[bench/tb_top.sv]
// Top of the path table bench: clock, reset, request stimulus and response
// back-pressure, with the verdict taken from path_table_monitor.
// Depends on mwpt_pkg, mwpt_if, min_weight_path_table_core and the monitor.
`timescale 1ns / 1ps

module tb_top
   import mwpt_pkg::*;
   ;

   logic clock;
   logic reset;
   int   failures;
   int   awaited;
   bit   quiet;

   // Paths believed held, used only to aim removes, duplicates and queries.
   entry_type live_paths[$];

   mwpt_req_if req_bus ();
   mwpt_rsp_if rsp_bus ();

   min_weight_path_table_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   path_table_monitor monitor (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_bus),
      .rsp_mon  (rsp_bus),
      .failures (failures),
      .awaited  (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle lengths: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Weights lean towards a few small values so that ties are common.
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return {16'($urandom_range(0, 3)),
                         ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h0000};
      return $urandom;
   endfunction

   // Keeps the stimulus-side view of the table in step with one request.
   function automatic void track(mode_type op, logic [ID_W-1:0] id,
                                 logic [WEIGHT_W-1:0] weight, logic [NODE_W-1:0] node);
      entry_type e;
      int        slot;
      slot = -1;
      if (op == MODE_INSERT && live_paths.size() < CAPACITY) begin
         e.id     = id;
         e.weight = weight;
         e.node   = node;
         live_paths.push_back(e);
      end else if (op == MODE_REMOVE) begin
         foreach (live_paths[i]) begin
            if (slot < 0 && live_paths[i].id == id) slot = i;
         end
         if (slot >= 0) live_paths.delete(slot);
      end
   endfunction

   // Presents one request word, holds it until taken, then idles for a random gap, often none.
   task automatic send(mode_type op, logic [ID_W-1:0] id,
                       logic [WEIGHT_W-1:0] weight, logic [NODE_W-1:0] node);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= op;
      req_bus.path_id <= id;
      req_bus.weight  <= weight;
      req_bus.node_id <= node;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track(op, id, weight, node);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One random request; kind 0 fills the table, kind 2 drains it, else mixed.
   task automatic send_random(int kind);
      mode_type          op;
      logic [ID_W-1:0]   id;
      logic [NODE_W-1:0] node;
      int                r;
      int                insert_pct;
      int                remove_pct;
      insert_pct = (kind == 0) ? 75 : (kind == 2) ? 15 : 35;
      remove_pct = (kind == 2) ? 65 : 25;
      r = $urandom_range(0, 99);
      if (r < insert_pct) op = MODE_INSERT;
      else if (r < insert_pct + remove_pct) op = MODE_REMOVE;
      else if (r < insert_pct + remove_pct + (100 - insert_pct - remove_pct) / 2)
         op = MODE_FINDMIN;
      else op = MODE_QUERY;

      id   = 16'($urandom_range(0, 65535));
      node = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      if (live_paths.size() > 0) begin
         r = $urandom_range(0, live_paths.size() - 1);
         // Removes mostly hit; a few inserts reuse a held id.
         if (op == MODE_REMOVE && $urandom_range(0, 3) != 0) id = live_paths[r].id;
         if (op == MODE_INSERT && $urandom_range(0, 19) == 0) id = live_paths[r].id;
         if (op == MODE_QUERY && $urandom_range(0, 9) < 6) node = live_paths[r].node;
      end
      send(op, id, pick_weight(), node);
   endtask

   // Response side: ready is dropped for random stretches.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Reset, directed words, random phases, drain and verdict.
   initial begin
      reset           <= 1'b1;
      quiet           = 1'b0;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_INSERT;
      req_bus.path_id <= '0;
      req_bus.weight  <= '0;
      req_bus.node_id <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: every lookup misses.
      send(MODE_FINDMIN, 16'h0000, 32'h0000_0000, 16'h0000);
      send(MODE_QUERY,   16'h0000, 32'h0000_0000, 16'h0000);
      send(MODE_REMOVE,  16'h0000, 32'h0000_0000, 16'h0000);
      // Field extremes and a weight tie.
      send(MODE_INSERT,  16'h0000, 32'h0000_0000, 16'h0000);
      send(MODE_INSERT,  16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send(MODE_INSERT,  16'h1234, 32'h0001_8000, 16'h0007);
      send(MODE_INSERT,  16'h1235, 32'h0001_8000, 16'h0008);
      send(MODE_FINDMIN, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send(MODE_REMOVE,  16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
      // The tie goes to the earlier slot.
      send(MODE_FINDMIN, 16'h0000, 32'h0000_0000, 16'h0000);
      send(MODE_QUERY,   16'h0000, 32'h0000_0000, 16'hFFFF);
      send(MODE_QUERY,   16'hFFFF, 32'hFFFF_FFFF, 16'h0009);
      send(MODE_REMOVE,  16'h5555, 32'h0000_0000, 16'h0000);
      // A repeated id: remove takes only the lower slot.
      send(MODE_INSERT,  16'h1235, 32'h0000_0005, 16'h0003);
      send(MODE_REMOVE,  16'h1235, 32'h0000_0000, 16'h0000);
      send(MODE_FINDMIN, 16'h0000, 32'h0000_0000, 16'h0000);
      // Remove from the first and the last slot, then empty the table.
      send(MODE_REMOVE,  16'hFFFF, 32'h0000_0000, 16'h0000);
      send(MODE_REMOVE,  16'h1235, 32'h0000_0000, 16'h0000);
      send(MODE_QUERY,   16'h0000, 32'h0000_0000, 16'h0007);
      send(MODE_REMOVE,  16'h1234, 32'h0000_0000, 16'h0000);
      send(MODE_FINDMIN, 16'h0000, 32'h0000_0000, 16'h0000);

      // Random phases of 100 words: fill to capacity, mix, drain, mix.
      for (int phase = 0; phase < 11; phase++) begin
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 100; n++) send_random(phase % 4);
      end
      if (req_bus.valid) req_bus.valid <= 1'b0;

      // Wait for the last responses, then allow for the longest operation.
      repeat (2) @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hang guard, several times the slowest correct run.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
